// ===== hdl/alopex_pkg.sv =====
// Package: constants, types and sigmoid table for the Alopex update engine.
`default_nettype none
package alopex_pkg;
  localparam int NUM_PARAMS = 1024;
  localparam int IDX_W = 10;
  localparam logic signed [63:0] VMAX = 64'sd2147483647;
  localparam logic signed [63:0] VMIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0, CMD_BEGIN = 2'd1, CMD_UPDATE = 2'd2, CMD_FINISH = 2'd3
  } cmd_t;
  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_TAU = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_LAMBDA = 2'd1;
  localparam logic [1:0] REG_TAU = 2'd2;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_B0    = 11'b00000000010,
    ST_B1    = 11'b00000000100,
    ST_B2    = 11'b00000001000,
    ST_DIV1  = 11'b00000010000,
    ST_SIG   = 11'b00000100000,
    ST_DIV2  = 11'b00001000000,
    ST_B3    = 11'b00010000000,
    ST_U0    = 11'b00100000000,
    ST_U1    = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  function automatic logic [15:0] sig_tab(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0: r = 16'd32768;
      4'd1: r = 16'd47911;
      4'd2: r = 16'd57724;
      4'd3: r = 16'd62428;
      4'd4: r = 16'd64358;
      4'd5: r = 16'd65097;
      4'd6: r = 16'd65374;
      4'd7: r = 16'd65476;
      default: r = 16'd65514;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/alopex_parameter_perturber_unit.sv =====
// Top level: Alopex update engine with a shared multiplier and a radix-2 divider.
//   channel | ports                | contents
//   in      | in_tvalid/tready     | tdata: cmd,kind,param_index,value,temperature,
//           |                      |        random_fraction,mask_on (low bit up)
//   out     | out_tvalid/tready    | tdata: result_value; tuser: status
//   cfg     | cfg_we/index/data    | step_size, memory_weight, tau_floor
// Init and finish go straight to output; update steps through history read, multiply, output.
// Begin steps through B0-B2, two 48-bit serial divisions with the sigmoid step between them, and B3.
// Reset is synchronous; the history memories hold no reset.
// The block is busy from acceptance until its result is taken.
`default_nettype none
module alopex_parameter_perturber_unit import alopex_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd[1:0] kind[3:2] param_index[13:4] value[45:14] temperature[76:46]
  // random_fraction[92:77] mask_on[93]
  input  wire logic [95:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_value[31:0]
  output logic [31:0]       out_tdata,
  // status[0]
  output logic              out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);
  state_t st_r, st_nxt;
  logic [16:0] step_r;
  logic [15:0] lam_r;
  logic [30:0] tfl_r;
  logic signed [31:0] en_r, em_r, eo_r, dlt_r, dot_r;
  logic [31:0] mp_r, mc_r;
  logic [15:0] pr_r;
  logic [1:0] kind_r;
  logic [IDX_W-1:0] idx_r;
  logic signed [31:0] val_r;
  logic [30:0] temp_r;
  logic [15:0] rnd_r;
  logic mask_r, flag_r;
  logic signed [31:0] res_r;
  logic signed [31:0] hl_r, hb_r;
  logic signed [63:0] acc_r;
  // divider
  logic [47:0] dq_r;
  logic [31:0] dd_r;
  logic [32:0] rem_r;
  logic [5:0] cnt_r;
  logic neg_r;

  logic signed [31:0] mem_l [NUM_PARAMS];
  logic signed [31:0] mem_b [NUM_PARAMS];

  // shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  assign mprod = ma * mb;

  logic [32:0] rtry;
  assign rtry = {rem_r[31:0], dq_r[47]} - {1'b0, dd_r};

  logic signed [32:0] dsum;
  logic signed [32:0] hd;
  logic signed [31:0] dsat, dab;
  logic [31:0] mag;
  logic [15:0] p;
  logic signed [63:0] pr64, pm64;
  logic signed [47:0] chg;
  logic signed [48:0] nv;
  logic signed [31:0] res_u;

  always_comb begin
    ma = '0; mb = '0;
    unique case (st_r)
      ST_B1: begin ma = {2'b0, dab}; mb = {18'b0, lam_r}; end
      ST_B2: begin ma = {2'b0, mp_r}; mb = 34'(17'h10000 - {1'b0, lam_r}); end
      ST_SIG: begin
        ma = 34'(sig_tab(4'({1'b0, dq_r[18:16]} + 4'd1)) - sig_tab({1'b0, dq_r[18:16]}));
        mb = {18'b0, dq_r[15:0]};
      end
      ST_U1: begin ma = 34'(dot_r); mb = 34'(dsat); end
      default: ;
    endcase
  end

  always_comb begin
    dsum = 33'(em_r) - 33'(eo_r);
    dab = (dsum < 0) ? 32'(-dsum) : 32'(dsum);
    if (dsum > 33'sd2147483647 || -dsum > 33'sd2147483647) dab = 32'h7fffffff;
    mag = dlt_r[31] ? 32'(-33'(dlt_r)) : 32'(dlt_r);
    hd = 33'(hl_r) - 33'(hb_r);
    dsat = (hd > 33'sd2147483647) ? 32'h7fffffff :
           (hd < -33'sd2147483648) ? 32'h80000000 : 32'(hd);
    p = dsat[31] ? 16'(17'h10000 - {1'b0, pr_r}) : pr_r;
    pr64 = 64'(mprod);
    pm64 = pr64[63] ? -pr64 : pr64;
    chg = pr64[63] ? -48'(pm64 >>> 16) : 48'(pm64 >>> 16);
    chg = chg + ((rnd_r < p) ? -48'(step_r) : 48'(step_r));
    if (kind_r != KIND_WEIGHT && !mask_r) chg = '0;
    nv = 49'(val_r) + 49'(chg);
    res_u = (nv > 49'sd2147483647) ? 32'h7fffffff :
            (nv < -49'sd2147483648) ? 32'h80000000 : 32'(nv);
    if (kind_r == KIND_TAU && res_u < $signed({1'b0, tfl_r})) res_u = $signed({1'b0, tfl_r});
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) begin
        unique case (cmd_t'(in_tdata[1:0]))
          CMD_BEGIN: st_nxt = ST_B0;
          CMD_UPDATE: st_nxt = ST_U0;
          default: st_nxt = ST_OUT;
        endcase
      end
      ST_B0: st_nxt = ST_B1;
      ST_B1: st_nxt = ST_B2;
      ST_B2: st_nxt = ST_DIV1;
      ST_DIV1: if (cnt_r == 6'd0) st_nxt = ST_SIG;
      ST_SIG: st_nxt = ST_DIV2;
      ST_DIV2: if (cnt_r == 6'd0) st_nxt = ST_B3;
      ST_B3: st_nxt = ST_OUT;
      ST_U0: st_nxt = ST_U1;
      ST_U1: st_nxt = ST_OUT;
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = res_r;
  assign out_tuser = flag_r;

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_tvalid && cmd_t'(in_tdata[1:0]) == CMD_INIT) begin
      mem_l[in_tdata[4+IDX_W-1:4]] <= in_tdata[45:14];
      mem_b[in_tdata[4+IDX_W-1:4]] <= in_tdata[45:14];
    end
    if (st_r == ST_U1) begin
      mem_b[idx_r] <= hl_r;
      mem_l[idx_r] <= res_u;
    end
    hl_r <= mem_l[idx_r];
    hb_r <= mem_b[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      step_r <= 17'd6554; lam_r <= 16'd36045; tfl_r <= '0;
      en_r <= '0; em_r <= '0; eo_r <= '0; mp_r <= '0; mc_r <= '0;
      dlt_r <= '0; dot_r <= '0; pr_r <= 16'd32768;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP: step_r <= cfg_data[16:0];
          REG_LAMBDA: lam_r <= cfg_data[15:0];
          REG_TAU: tfl_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: if (in_tvalid) begin
          kind_r <= in_tdata[3:2];
          idx_r <= in_tdata[4+IDX_W-1:4]; val_r <= in_tdata[45:14];
          temp_r <= in_tdata[76:46]; rnd_r <= in_tdata[92:77];
          mask_r <= in_tdata[93];
          flag_r <= 1'b0; res_r <= '0;
          unique case (cmd_t'(in_tdata[1:0]))
            CMD_INIT: begin en_r <= '0; em_r <= '0; eo_r <= '0; mp_r <= '0; end
            CMD_FINISH: begin
              eo_r <= em_r; em_r <= en_r; en_r <= in_tdata[45:14]; mp_r <= mc_r;
            end
            default: ;
          endcase
        end
        ST_B0: begin
          if (en_r == 0 && em_r == 0 && eo_r == 0) begin
            en_r <= val_r; em_r <= val_r; eo_r <= val_r;
          end
        end
        ST_B1: begin
          // error_delta
          if (33'(en_r) - 33'(em_r) > 33'sd2147483647) begin
            dlt_r <= 32'h7fffffff; flag_r <= 1'b1;
          end else if (33'(en_r) - 33'(em_r) < -33'sd2147483648) begin
            dlt_r <= 32'h80000000; flag_r <= 1'b1;
          end else dlt_r <= 32'(33'(en_r) - 33'(em_r));
          if (dsum > 33'sd2147483647 || -dsum > 33'sd2147483647) flag_r <= 1'b1;
          acc_r <= 64'(mprod);
        end
        ST_B2: begin
          mc_r <= 32'((acc_r + 64'(mprod)) >>> 16);
          dq_r <= {mag, 16'b0};
          dd_r <= 32'((acc_r + 64'(mprod)) >>> 16);
          rem_r <= '0; cnt_r <= 6'd48;
        end
        ST_DIV1, ST_DIV2: begin
          if (cnt_r != 6'd0) begin
            if (dd_r == 0) cnt_r <= 6'd0;
            else begin
              if (!rtry[32]) begin
                rem_r <= rtry; dq_r <= {dq_r[46:0], 1'b1};
              end else begin
                rem_r <= {rem_r[31:0], dq_r[47]}; dq_r <= {dq_r[46:0], 1'b0};
              end
              cnt_r <= cnt_r - 6'd1;
            end
          end
        end
        default: ;
      endcase
      if (st_r == ST_SIG) begin
        if (mc_r == 0) begin
          pr_r <= 16'd32768; flag_r <= 1'b1;
        end else begin
          logic [15:0] s;
          s = (dq_r[47:19] != 0) ? sig_tab(4'd8)
              : 16'(sig_tab({1'b0, dq_r[18:16]}) + 16'(mprod >>> 16));
          pr_r <= dlt_r[31] ? 16'(17'h10000 - {1'b0, s}) : s;
        end
        dq_r <= {mag, 16'b0};
        dd_r <= {1'b0, temp_r};
        neg_r <= dlt_r[31];
        rem_r <= '0; cnt_r <= 6'd48;
      end
      if (st_r == ST_B3) begin
        res_r <= $signed(mc_r);
        if (temp_r == 0) begin
          flag_r <= 1'b1;
          dot_r <= (dlt_r > 0) ? 32'h7fffffff : (dlt_r < 0) ? 32'h80000000 : 32'h0;
        end else if (!neg_r && dq_r > 48'h7fffffff) begin
          dot_r <= 32'h7fffffff; flag_r <= 1'b1;
        end else if (neg_r && dq_r > 48'h80000000) begin
          dot_r <= 32'h80000000; flag_r <= 1'b1;
        end else dot_r <= neg_r ? 32'(-dq_r) : 32'(dq_r);
      end
      if (st_r == ST_U1) begin
        res_r <= res_u;
        if (hd != 33'(dsat)) flag_r <= 1'b1;
        if (nv > 49'sd2147483647 || nv < -49'sd2147483648) flag_r <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/alopex_parameter_perturber_unit_tb.sv =====
// Testbench for the Alopex update engine: shadow update model, directed and random stream stimulus.
`default_nettype none
class alopex_scoreboard;
  bit [16:0] step_size;
  bit [15:0] lambda;
  bit [30:0] tau_floor;
  longint err_new, err_mid, err_old;
  longint unsigned mem_prev, mem_cur;
  longint err_delta, drift_factor;
  longint unsigned p_rise;
  longint hist_last[1024];
  longint hist_before[1024];
  bit [31:0] value_q[$];
  bit status_q[$];
  int errors;
  int checked;

  function new();
    step_size = 17'd6554;
    lambda = 16'd36045;
    tau_floor = '0;
    err_new = 0; err_mid = 0; err_old = 0;
    mem_prev = 0; mem_cur = 0;
    err_delta = 0; drift_factor = 0;
    p_rise = 32768;
    errors = 0;
    checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [30:0] data);
    if (idx == alopex_pkg::REG_STEP) step_size = data[16:0];
    else if (idx == alopex_pkg::REG_LAMBDA) lambda = data[15:0];
    else if (idx == alopex_pkg::REG_TAU) tau_floor = data;
  endfunction

  function longint clamp32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function longint unsigned sig_interp(longint unsigned x);
    longint unsigned tab[9];
    longint unsigned i, f;
    tab = '{32768, 47911, 57724, 62428, 64358, 65097, 65374, 65476, 65514};
    if (x >= 8 * 65536) return tab[8];
    i = x >> 16;
    f = x & 64'hFFFF;
    return tab[i] + (((tab[i + 1] - tab[i]) * f) >> 16);
  endfunction

  function void note_item(logic [95:0] d);
    alopex_pkg::cmd_t cmd;
    logic [1:0] kind;
    int idx;
    longint val, temp, res, d1, dh, step, prod, drift, change;
    longint unsigned acc, mag, rnd, pp, pm, s;
    bit mask, f;
    cmd = alopex_pkg::cmd_t'(d[1:0]);
    kind = d[3:2];
    idx = d[13:4];
    val = longint'($signed(d[45:14]));
    temp = longint'(d[76:46]);
    rnd = d[92:77];
    mask = d[93];
    f = 0;
    res = 0;
    case (cmd)
      alopex_pkg::CMD_INIT: begin
        hist_last[idx] = val;
        hist_before[idx] = val;
        err_new = 0; err_mid = 0; err_old = 0;
        mem_prev = 0;
      end
      alopex_pkg::CMD_BEGIN: begin
        if (err_new == 0 && err_mid == 0 && err_old == 0) begin
          err_new = val; err_mid = val; err_old = val;
        end
        err_delta = clamp32(err_new - err_mid, f);
        d1 = err_mid - err_old;
        if (d1 < 0) d1 = -d1;
        if (d1 > 64'sd2147483647) begin
          d1 = 64'sd2147483647;
          f = 1;
        end
        acc = longint'(d1) * lambda + (65536 - longint'(lambda)) * mem_prev;
        mem_cur = (acc >> 16) & 64'hFFFF_FFFF;
        mag = err_delta < 0 ? -err_delta : err_delta;
        if (mem_cur == 0) begin
          p_rise = 32768;
          f = 1;
        end else begin
          s = sig_interp((mag << 16) / mem_cur);
          p_rise = err_delta < 0 ? 65536 - s : s;
        end
        if (temp == 0) begin
          f = 1;
          drift_factor = err_delta > 0 ? 64'sd2147483647 :
                         (err_delta < 0 ? -64'sd2147483648 : 0);
        end else begin
          drift_factor = clamp32((err_delta * 65536) / temp, f);
        end
        res = mem_cur;
      end
      alopex_pkg::CMD_UPDATE: begin
        dh = clamp32(hist_last[idx] - hist_before[idx], f);
        pp = dh < 0 ? 65536 - p_rise : p_rise;
        step = rnd < pp ? -longint'(step_size) : longint'(step_size);
        prod = drift_factor * dh;
        pm = prod < 0 ? -prod : prod;
        drift = prod < 0 ? -longint'(pm >> 16) : longint'(pm >> 16);
        change = step + drift;
        if (kind != alopex_pkg::KIND_WEIGHT && !mask) change = 0;
        res = clamp32(val + change, f);
        if (kind == alopex_pkg::KIND_TAU && res < longint'(tau_floor))
          res = longint'(tau_floor);
        hist_before[idx] = hist_last[idx];
        hist_last[idx] = res;
      end
      default: begin
        err_old = err_mid;
        err_mid = err_new;
        err_new = val;
        mem_prev = mem_cur;
      end
    endcase
    value_q.push_back(res[31:0]);
    status_q.push_back(f);
  endfunction

  function void check_result(logic [31:0] v, logic st);
    bit [31:0] ev;
    bit es;
    if (value_q.size() == 0) begin
      $error("result with nothing pending: result_value %h status %b", v, st);
      errors++;
      return;
    end
    ev = value_q.pop_front();
    es = status_q.pop_front();
    checked++;
    if (v !== ev) begin
      $error("result_value: expected %h actual %h", ev, v);
      errors++;
    end
    if (st !== es) begin
      $error("status: expected %b actual %b", es, st);
      errors++;
    end
  endfunction
endclass

module alopex_parameter_perturber_unit_tb;
  import alopex_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;

  alopex_scoreboard sb;
  bit written[1024];
  int written_list[$];
  int sent;
  int n_begin, n_update;
  bit hold_req;
  longint cycles;

  alopex_parameter_perturber_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("alopex_parameter_perturber_unit_tb: errors");
      $finish;
    end
  end

  task automatic send_item(cmd_t cmd, logic [1:0] kind, int idx, logic [31:0] val,
                           logic [30:0] temp, logic [15:0] rnd, logic mask);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, mask, rnd, temp, val, idx[9:0], kind, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item({2'b00, mask, rnd, temp, val, idx[9:0], kind, cmd});
    sent++;
    if (cmd == CMD_INIT && !written[idx]) begin
      written[idx] = 1;
      written_list.push_back(idx);
    end
    if (cmd == CMD_BEGIN) n_begin++;
    if (cmd == CMD_UPDATE) n_update++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.value_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 131072) - 65536;
      2: return $urandom_range(0, 1 << 24) - (1 << 23);
      default: return {$urandom_range(0, 1) ? 32'h7FFF0000 : 32'h80000000}
                      | $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [30:0] rand_temp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(1, 65536);
      2: return $urandom_range(0, 8);
      default: return $urandom_range(65536, 1 << 22);
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic random_update();
    send_item(CMD_UPDATE, $urandom_range(0, 3), pick_written(), rand_val(),
              31'd0, $urandom(), $urandom_range(0, 1));
  endtask

  task automatic run_random(int count);
    int stop, n, i, idx;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 5) == 0)
          send_item(CMD_INIT, $urandom_range(0, 3), $urandom_range(0, 1023), rand_val(),
                    $urandom(), $urandom(), $urandom_range(0, 1));
        send_item(CMD_BEGIN, $urandom_range(0, 3), $urandom_range(0, 1023), rand_val(),
                  rand_temp(), $urandom(), $urandom_range(0, 1));
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) random_update();
        send_item(CMD_FINISH, $urandom_range(0, 3), $urandom_range(0, 1023), rand_val(),
                  $urandom(), $urandom(), $urandom_range(0, 1));
      end else begin
        idx = $urandom_range(0, 1023);
        case ($urandom_range(0, 3))
          0: send_item(CMD_INIT, $urandom_range(0, 3), idx, $urandom(), $urandom(),
                       $urandom(), $urandom_range(0, 1));
          1: send_item(CMD_BEGIN, $urandom_range(0, 3), idx, $urandom(), $urandom(),
                       $urandom(), $urandom_range(0, 1));
          2: random_update();
          default: send_item(CMD_FINISH, $urandom_range(0, 3), idx, $urandom(),
                             $urandom(), $urandom(), $urandom_range(0, 1));
        endcase
      end
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      w = $urandom_range(0, 3);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    sb = new();
    cycles = 0;
    sent = 0; n_begin = 0; n_update = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(CMD_INIT, KIND_WEIGHT, 0, 32'h7FFFFFFF, 31'h7FFFFFFF, 16'hFFFF, 1'b1);
    send_item(CMD_INIT, 2'd3, 1023, 32'h80000000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_INIT, KIND_TAU, 5, 32'h00010000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_BEGIN, KIND_WEIGHT, 0, 32'h00020000, 31'd65536, 16'd0, 1'b0);
    send_item(CMD_UPDATE, KIND_WEIGHT, 0, 32'h7FFFFFFF, 31'd0, 16'hFFFF, 1'b0);
    send_item(CMD_UPDATE, KIND_WEIGHT, 1023, 32'h80000000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_FINISH, KIND_WEIGHT, 0, 32'h80000000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_BEGIN, KIND_WEIGHT, 0, 32'h7FFFFFFF, 31'd0, 16'd0, 1'b0);
    send_item(CMD_UPDATE, KIND_TAU, 5, 32'hFFFF0000, 31'd0, 16'd100, 1'b1);
    send_item(CMD_UPDATE, 2'd2, 0, 32'h00001000, 31'd0, 16'd100, 1'b0);
    send_item(CMD_UPDATE, 2'd3, 1023, 32'h00001000, 31'd0, 16'hFFFF, 1'b1);
    send_item(CMD_UPDATE, KIND_TAU, 5, 32'h00001000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_FINISH, KIND_WEIGHT, 0, 32'h00010000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_BEGIN, KIND_WEIGHT, 0, 32'h00030000, 31'd1, 16'd0, 1'b0);
    send_item(CMD_UPDATE, KIND_WEIGHT, 0, 32'd0, 31'd0, 16'd32768, 1'b0);
    send_item(CMD_FINISH, KIND_WEIGHT, 0, 32'hFFFD0000, 31'd0, 16'd0, 1'b0);
    send_item(CMD_BEGIN, KIND_WEIGHT, 0, 32'd0, 31'h7FFFFFFF, 16'd0, 1'b0);
    send_item(CMD_UPDATE, KIND_WEIGHT, 1023, 32'd12345, 31'd0, 16'd40000, 1'b1);
    drain();

    write_reg(REG_STEP, 31'd65536);
    write_reg(REG_LAMBDA, 31'd65535);
    write_reg(REG_TAU, 31'h7FFFFFFF);
    run_random(500);
    hold_req = 1;
    run_random(30);
    drain();

    write_reg(REG_STEP, 31'd0);
    write_reg(REG_LAMBDA, 31'd0);
    write_reg(REG_TAU, 31'd0);
    run_random(450);
    drain();

    write_reg(REG_STEP, $urandom_range(0, 65536));
    write_reg(REG_LAMBDA, $urandom_range(0, 65535));
    write_reg(REG_TAU, $urandom_range(0, 1 << 20));
    run_random(450);
    drain();

    write_reg(REG_STEP, 31'd6554);
    write_reg(REG_LAMBDA, 31'd36045);
    write_reg(REG_TAU, 31'd65536);
    run_random(500);
    drain();

    $display("run covered %0d items (%0d begin, %0d update), %0d results checked,",
             sent, n_begin, n_update, sb.checked);
    $display("four register settings, a long output hold-off and full drains");
    if (sb.errors == 0 && sb.value_q.size() == 0) begin
      $display("alopex_parameter_perturber_unit_tb: clean");
    end else begin
      $display("alopex_parameter_perturber_unit_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/alopex_pkg.sv
hdl/alopex_parameter_perturber_unit.sv
verif/alopex_parameter_perturber_unit_tb.sv
